[hdl/svl_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted unique value list: shared package
// Sizes, codes and the command and status bundles between the controller and
// the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package svl_pkg;

  // List storage.
  localparam int CAPACITY = 512;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the stream words.
  localparam int VAL_W      = 16;
  localparam int POS_W      = 9;
  localparam int ENTRY_W    = 10;
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - VAL_W - ENTRY_W - STAT_W;

  // Configuration register reset values.
  localparam logic [VAL_W-1:0] FLOOR_RESET   = 16'd3;
  localparam logic [VAL_W-1:0] CEILING_RESET = 16'd6000;

  // Operation carried in tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  // Result status.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_FLOOR   = 1'b0,
    REG_CEILING = 1'b1
  } reg_index_t;

  // What the datapath does with a word when it returns from the memory.
  typedef enum logic [1:0] {
    RD_FETCH,
    RD_SCAN,
    RD_UP,
    RD_DOWN
  } rd_op_t;

  // Pointer update.
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_DEC,
    PTR_ZERO,
    PTR_COUNT,
    PTR_POS,
    PTR_POS_NEXT
  } ptr_sel_t;

  // Source of the result value.
  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_CLAMP,
    VAL_FETCH
  } val_sel_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SCAN_END,
    S_SHIFT_UP,
    S_PLACE,
    S_SHIFT_DOWN,
    S_READ,
    S_FINISH
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic     load;
    logic     issue;
    rd_op_t   rd_op;
    ptr_sel_t ptr_sel;
    logic     place;
    logic     shrink;
    logic     finish;
    status_t  res_status;
    val_sel_t res_sel;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    kind_t kind;
    logic  pos_bad;
    logic  ptr_lt_count;
    logic  ptr_gt_slot;
    logic  dup;
    logic  full;
    logic  out_busy;
  } stat_t;

endpackage

`default_nettype wire

[hdl/svl_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted unique value list: controller
// Sequences the scan, shift, place and read steps of one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module svl_ctrl
  import svl_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t   state, state_next;
  status_t  res_status, res_status_next;
  val_sel_t res_sel, res_sel_next;

  // State and pending result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_DONE;
      res_sel    <= VAL_ZERO;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_sel    <= res_sel_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_sel_next    = res_sel;
    s_tready        = 1'b0;
    cmd             = '0;
    cmd.rd_op       = RD_FETCH;
    cmd.ptr_sel     = PTR_HOLD;
    cmd.res_status  = res_status;
    cmd.res_sel     = res_sel;

    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        case (stat.kind)
          KIND_INSERT: begin
            cmd.ptr_sel = PTR_ZERO;
            state_next  = S_SCAN;
          end
          KIND_DELETE: begin
            if (stat.pos_bad) begin
              res_status_next = ST_RANGE;
              res_sel_next    = VAL_ZERO;
              state_next      = S_FINISH;
            end else begin
              cmd.ptr_sel = PTR_POS_NEXT;
              state_next  = S_SHIFT_DOWN;
            end
          end
          KIND_READ: begin
            if (stat.pos_bad) begin
              res_status_next = ST_RANGE;
              res_sel_next    = VAL_ZERO;
              state_next      = S_FINISH;
            end else begin
              cmd.ptr_sel = PTR_POS;
              state_next  = S_READ;
            end
          end
          default: begin
            res_status_next = ST_DONE;
            res_sel_next    = VAL_ZERO;
            state_next      = S_FINISH;
          end
        endcase
      end

      // Read every entry once; the datapath counts smaller ones and spots a match.
      S_SCAN: begin
        if (stat.ptr_lt_count) begin
          cmd.issue   = 1'b1;
          cmd.rd_op   = RD_SCAN;
          cmd.ptr_sel = PTR_INC;
        end else begin
          state_next = S_SCAN_END;
        end
      end

      S_SCAN_END: begin
        if (stat.dup) begin
          res_status_next = ST_DUP;
          res_sel_next    = VAL_CLAMP;
          state_next      = S_FINISH;
        end else if (stat.full) begin
          res_status_next = ST_FULL;
          res_sel_next    = VAL_CLAMP;
          state_next      = S_FINISH;
        end else begin
          cmd.ptr_sel = PTR_COUNT;
          state_next  = S_SHIFT_UP;
        end
      end

      // Move entries at and above the slot up by one, top first.
      S_SHIFT_UP: begin
        if (stat.ptr_gt_slot) begin
          cmd.issue   = 1'b1;
          cmd.rd_op   = RD_UP;
          cmd.ptr_sel = PTR_DEC;
        end else begin
          state_next = S_PLACE;
        end
      end

      S_PLACE: begin
        cmd.place       = 1'b1;
        res_status_next = ST_DONE;
        res_sel_next    = VAL_CLAMP;
        state_next      = S_FINISH;
      end

      // Move entries above the position down by one, bottom first.
      S_SHIFT_DOWN: begin
        if (stat.ptr_lt_count) begin
          cmd.issue   = 1'b1;
          cmd.rd_op   = RD_DOWN;
          cmd.ptr_sel = PTR_INC;
        end else begin
          cmd.shrink      = 1'b1;
          res_status_next = ST_DONE;
          res_sel_next    = VAL_ZERO;
          state_next      = S_FINISH;
        end
      end

      S_READ: begin
        cmd.issue       = 1'b1;
        cmd.rd_op       = RD_FETCH;
        res_status_next = ST_DONE;
        res_sel_next    = VAL_FETCH;
        state_next      = S_FINISH;
      end

      // Hand the result to the output register once it has room.
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/svl_dp.sv]
// ----------------------------------------------------------------------------
// Sorted unique value list: datapath
// Entry memory, count, scan pointer, clamp, configuration and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module svl_dp
  import svl_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire  [IN_DATA_W-1:0]  s_tdata,
  input  wire  [KIND_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  wire                   cfg_valid,
  input  wire  [0:0]            cfg_index,
  input  wire  [VAL_W-1:0]      cfg_data,
  input  cmd_t                  cmd,
  output stat_t                 stat
);

  logic [VAL_W-1:0]  mem [CAPACITY];
  logic [VAL_W-1:0]  size_floor, size_ceiling;
  logic [CNT_W-1:0]  count, ptr, slot;
  kind_t             kind;
  logic [VAL_W-1:0]  val;
  logic [POS_W-1:0]  pos;
  logic              dup;
  logic              rvalid;
  rd_op_t            rop;
  logic [ADDR_W-1:0] rtag;
  logic [VAL_W-1:0]  rdata;
  logic [VAL_W-1:0]  out_value;
  logic [ENTRY_W-1:0] out_total;
  status_t           out_status;

  logic [VAL_W-1:0]  in_value, clamped;
  logic [POS_W-1:0]  in_pos;
  logic [CNT_W-1:0]  ptr_m1;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [VAL_W-1:0]  wdata;
  logic [VAL_W-1:0]  res_value;

  assign in_value = s_tdata[VAL_W-1:0];
  assign in_pos   = s_tdata[VAL_W +: POS_W];

  // Clamp: a value below the floor is raised without a ceiling check.
  always_comb begin
    if (in_value < size_floor) begin
      clamped = size_floor;
    end else if (in_value > size_ceiling) begin
      clamped = size_ceiling;
    end else begin
      clamped = in_value;
    end
  end

  // Read address; a shift up reads one below the pointer.
  assign ptr_m1 = ptr - 1'b1;
  assign raddr  = (cmd.rd_op == RD_UP) ? ptr_m1[ADDR_W-1:0] : ptr[ADDR_W-1:0];

  // Single write port: returning shift words, or the new value on place.
  always_comb begin
    we    = 1'b0;
    waddr = rtag;
    wdata = rdata;
    if (cmd.place) begin
      we    = 1'b1;
      waddr = slot[ADDR_W-1:0];
      wdata = val;
    end else if (rvalid && rop == RD_UP) begin
      we    = 1'b1;
      waddr = rtag + 1'b1;
    end else if (rvalid && rop == RD_DOWN) begin
      we    = 1'b1;
      waddr = rtag - 1'b1;
    end
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.issue) begin
      rdata <= mem[raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_floor   <= FLOOR_RESET;
      size_ceiling <= CEILING_RESET;
      count        <= '0;
      rvalid       <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (reg_index_t'(cfg_index))
          REG_FLOOR:   size_floor   <= cfg_data;
          REG_CEILING: size_ceiling <= cfg_data;
          default:     size_floor   <= size_floor;
        endcase
      end
      rvalid <= cmd.issue;
      if (cmd.place) begin
        count <= count + 1'b1;
      end else if (cmd.shrink) begin
        count <= count - 1'b1;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Item, pointer and scan results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= kind_t'(s_tuser);
      val  <= clamped;
      pos  <= in_pos;
      dup  <= 1'b0;
      slot <= '0;
    end else if (rvalid && rop == RD_SCAN) begin
      if (rdata == val) begin
        dup <= 1'b1;
      end
      if (rdata < val) begin
        slot <= slot + 1'b1;
      end
    end

    case (cmd.ptr_sel)
      PTR_INC:      ptr <= ptr + 1'b1;
      PTR_DEC:      ptr <= ptr_m1;
      PTR_ZERO:     ptr <= '0;
      PTR_COUNT:    ptr <= count;
      PTR_POS:      ptr <= CNT_W'(pos);
      PTR_POS_NEXT: ptr <= CNT_W'(pos) + 1'b1;
      default:      ptr <= ptr;
    endcase

    rop  <= cmd.rd_op;
    rtag <= raddr;
  end

  // Result value and output register.
  always_comb begin
    case (cmd.res_sel)
      VAL_CLAMP: res_value = val;
      VAL_FETCH: res_value = rdata;
      default:   res_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value  <= res_value;
      out_total  <= ENTRY_W'(count);
      out_status <= cmd.res_status;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_status, out_total, out_value};

  // Status to the controller.
  always_comb begin
    stat.kind         = kind;
    stat.pos_bad      = (32'(pos) >= 32'(count));
    stat.ptr_lt_count = (ptr < count);
    stat.ptr_gt_slot  = (ptr > slot);
    stat.dup          = dup;
    stat.full         = (count == CNT_W'(CAPACITY));
    stat.out_busy     = m_tvalid && !m_tready;
  end

endmodule

`default_nettype wire

[hdl/sorted_unique_value_list.sv]
// Operation: a read fetches one entry; a delete shifts the entries above the position down;
//   an insert makes one pass that finds the slot and one that shifts larger entries up; a
//   duplicate or a refused insert ends after the first pass.
// Throughput: one word at a time; the next word is taken once the result is in the output
//   register, which holds it until the sink takes it.
// Reset: synchronous; empties the list and restores floor 3 and ceiling 6000.
// ----------------------------------------------------------------------------
// Sorted unique value list
// Ascending list of unique clamped values with insert, delete and read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_value_list
  import svl_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  input  wire  [IN_DATA_W-1:0]  s_tdata,   // size_value[15:0], position[24:16]
  input  wire  [KIND_W-1:0]     s_tuser,   // kind[1:0]
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // read_value[15:0], entry_total[25:16],
                                           // status[27:26]
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [0:0]            cfg_index,
  input  wire  [VAL_W-1:0]      cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // The configuration registers always accept a write.
  assign cfg_ready = 1'b1;

  svl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  svl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

[dv/sorted_unique_value_list_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted unique value list: stream testbench
// Drives insert, delete, read and no-op words into the block. An in-bench
// copy of the sorted list predicts every result word, and each result is
// compared field by field against the oldest prediction. The run covers the
// empty and the full list, clamping with the floor above the ceiling, and a
// long output stall that backs the block up into its input.
// ----------------------------------------------------------------------------

module sorted_unique_value_list_test
  import svl_pkg::*;
();

  localparam int IDLE_PCT    = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 4_000_000;

  // One input word as the bench sees it.
  typedef struct {
    kind_t            kind;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
  } list_op_t;

  // One result word.
  typedef struct {
    logic [VAL_W-1:0]   value;
    logic [ENTRY_W-1:0] total;
    status_t            status;
  } list_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index = '0;
  logic [VAL_W-1:0]      cfg_data = '0;

  // Predicted list state and limits.
  logic [VAL_W-1:0] list_mem [CAPACITY];
  int               list_count = 0;
  logic [VAL_W-1:0] floor_limit = FLOOR_RESET;
  logic [VAL_W-1:0] ceiling_limit = CEILING_RESET;

  list_op_t     op_queue[$];
  list_result_t predicted_results[$];
  list_op_t     drive_op;
  list_result_t seen_result;
  list_result_t want_result;

  int   words_queued = 0;
  int   words_sent = 0;
  int   results_seen = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bit   in_taken = 1'b0;
  bit   cfg_taken = 1'b0;
  bit   failed = 1'b0;

  // Both sides stop idling in a window of every 256 words.
  wire calm = (words_sent % 256) >= 192;

  sorted_unique_value_list dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Apply one operation to the predicted list and return the result word.
  function automatic list_result_t update_list(kind_t kind, logic [VAL_W-1:0] raw,
                                               logic [POS_W-1:0] pos);
    list_result_t     r;
    logic [VAL_W-1:0] v;
    int               slot;
    bit               hit;
    r.value  = '0;
    r.status = ST_DONE;
    case (kind)
      KIND_INSERT: begin
        // A value below the floor is raised without looking at the ceiling.
        if (raw < floor_limit) v = floor_limit;
        else if (raw > ceiling_limit) v = ceiling_limit;
        else v = raw;
        r.value = v;
        slot = list_count;
        hit = 1'b0;
        for (int i = 0; i < list_count; i++) begin
          if (list_mem[i] == v) begin
            hit = 1'b1;
            break;
          end
          if (list_mem[i] > v) begin
            slot = i;
            break;
          end
        end
        if (hit) begin
          r.status = ST_DUP;
        end else if (list_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = list_count; i > slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot] = v;
          list_count++;
        end
      end
      KIND_DELETE: begin
        if (pos >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
        end
      end
      KIND_READ: begin
        if (pos >= list_count) r.status = ST_RANGE;
        else r.value = list_mem[pos];
      end
      default: begin
      end
    endcase
    r.total = ENTRY_W'(list_count);
    return r;
  endfunction

  // Sample all handshakes at the rising edge: predict on each accepted input
  // word, check each accepted result word, and track register writes.
  always @(posedge clk) begin
    in_taken  = !rst && s_tvalid && s_tready;
    cfg_taken = !rst && cfg_valid && cfg_ready;
    if (cfg_taken) begin
      if (cfg_index == REG_FLOOR) floor_limit = cfg_data;
      else ceiling_limit = cfg_data;
    end
    if (in_taken) begin
      predicted_results.push_back(update_list(kind_t'(s_tuser), s_tdata[VAL_W-1:0],
                                              s_tdata[VAL_W +: POS_W]));
      words_sent++;
    end
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      seen_result.value  = m_tdata[VAL_W-1:0];
      seen_result.total  = m_tdata[VAL_W +: ENTRY_W];
      seen_result.status = status_t'(m_tdata[VAL_W+ENTRY_W +: STAT_W]);
      if (predicted_results.size() == 0) begin
        $error("result word with nothing pending: value %0d total %0d status %0d",
               seen_result.value, seen_result.total, seen_result.status);
        failed = 1'b1;
      end else begin
        want_result = predicted_results.pop_front();
        if (seen_result.value !== want_result.value) begin
          $error("read_value: expected %0d, got %0d", want_result.value,
                 seen_result.value);
          failed = 1'b1;
        end
        if (seen_result.total !== want_result.total) begin
          $error("entry_total: expected %0d, got %0d", want_result.total,
                 seen_result.total);
          failed = 1'b1;
        end
        if (seen_result.status !== want_result.status) begin
          $error("status: expected %s, got %s", want_result.status.name(),
                 seen_result.status.name());
          failed = 1'b1;
        end
      end
    end
  end

  // Source: offer the next queued word, holding it until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (op_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        drive_op = op_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-VAL_W-POS_W){1'b0}}, drive_op.pos, drive_op.value};
        s_tuser  <= drive_op.kind;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 40) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_op(kind_t kind, logic [VAL_W-1:0] value, logic [POS_W-1:0] pos);
    list_op_t op;
    op.kind  = kind;
    op.value = value;
    op.pos   = pos;
    op_queue.push_back(op);
    words_queued++;
  endtask

  // Returns at a falling edge once every queued word has been answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (words_sent != words_queued || predicted_results.size() != 0);
  endtask

  // Writes both limit registers back to back; called at a falling edge.
  task automatic set_limits(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FLOOR;
    cfg_data  <= lo;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_index <= REG_CEILING;
    cfg_data  <= hi;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic with positions up to the expected count, and
  // about one word in ten of pure noise.
  task automatic queue_mixed(int n, int insert_pct);
    int               est;
    int               roll;
    logic [VAL_W-1:0] v;
    est = list_count;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        queue_op(kind_t'($urandom_range(3)), VAL_W'($urandom), POS_W'($urandom));
      end else if (roll < 10 + insert_pct) begin
        v = ($urandom_range(2) == 0) ? VAL_W'($urandom_range(40)) : VAL_W'($urandom);
        queue_op(KIND_INSERT, v, POS_W'($urandom));
        if (est < CAPACITY) est++;
      end else if (roll < 10 + insert_pct + (90 - insert_pct) / 2) begin
        queue_op(KIND_DELETE, VAL_W'($urandom), POS_W'($urandom_range(est)));
        if (est > 0) est--;
      end else begin
        queue_op(KIND_READ, VAL_W'($urandom), POS_W'($urandom_range(est)));
      end
    end
  endtask

  initial begin
    int               fill_words;
    logic [VAL_W-1:0] stored;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty list, clamping at both limits, duplicates, ends and middle.
    queue_op(KIND_READ, 16'd0, 9'd0);
    queue_op(KIND_DELETE, 16'd0, 9'd0);
    queue_op(KIND_NOP, 16'hFFFF, 9'd511);
    queue_op(KIND_INSERT, 16'd0, 9'd0);
    queue_op(KIND_INSERT, 16'hFFFF, 9'd511);
    queue_op(KIND_INSERT, 16'd6000, 9'd0);
    queue_op(KIND_INSERT, 16'd2, 9'd0);
    queue_op(KIND_INSERT, 16'd100, 9'd0);
    queue_op(KIND_INSERT, 16'd50, 9'd0);
    queue_op(KIND_INSERT, 16'd5999, 9'd0);
    queue_op(KIND_READ, 16'd0, 9'd0);
    queue_op(KIND_READ, 16'd0, 9'd4);
    queue_op(KIND_READ, 16'd0, 9'd5);
    queue_op(KIND_READ, 16'hFFFF, 9'd511);
    queue_op(KIND_DELETE, 16'd0, 9'd511);
    queue_op(KIND_DELETE, 16'd0, 9'd2);
    queue_op(KIND_DELETE, 16'd0, 9'd0);
    queue_op(KIND_DELETE, 16'd0, 9'd2);
    wait_drained();

    // Floor above the ceiling.
    set_limits(16'd1000, 16'd10);
    queue_op(KIND_INSERT, 16'd500, 9'd0);
    queue_op(KIND_INSERT, 16'd5000, 9'd0);
    queue_op(KIND_INSERT, 16'd0, 9'd0);
    queue_op(KIND_INSERT, 16'hFFFF, 9'd0);
    wait_drained();

    // General traffic; the long sink hold-off lands here.
    set_limits(VAL_W'($urandom_range(200)), VAL_W'($urandom_range(65535, 3000)));
    queue_mixed(30, 45);
    wait_drained();

    // Extreme limits: everything collapses onto two values.
    set_limits(16'hFFFF, 16'd0);
    queue_mixed(10, 50);
    wait_drained();

    // Open limits, fill the list to capacity.
    set_limits(16'd0, 16'hFFFF);
    fill_words = CAPACITY - list_count + 12;
    queue_op(KIND_INSERT, 16'd0, 9'd0);
    queue_op(KIND_INSERT, 16'hFFFF, 9'd0);
    for (int k = 0; k < fill_words; k++) begin
      if ($urandom_range(99) < 2)
        queue_op(KIND_READ, VAL_W'($urandom), POS_W'($urandom_range(CAPACITY - 1)));
      queue_op(KIND_INSERT, VAL_W'($urandom), POS_W'($urandom));
    end
    wait_drained();

    // Full list: duplicate, refused insert, last slot, then room again.
    stored = (list_count > 0) ? list_mem[$urandom_range(list_count - 1)] : 16'd0;
    queue_op(KIND_INSERT, stored, 9'd0);
    queue_op(KIND_INSERT, VAL_W'($urandom), 9'd0);
    queue_op(KIND_READ, 16'd0, 9'd511);
    queue_op(KIND_READ, 16'd0, 9'd0);
    queue_op(KIND_DELETE, 16'd0, 9'd511);
    queue_op(KIND_READ, 16'd0, 9'd511);
    queue_op(KIND_INSERT, stored, 9'd0);
    queue_op(KIND_DELETE, 16'd0, 9'd0);
    queue_op(KIND_INSERT, VAL_W'($urandom), 9'd0);
    wait_drained();

    // Random limits on a nearly full list; inserts, deletes and reads in equal shares.
    set_limits(VAL_W'($urandom), VAL_W'($urandom));
    queue_mixed(16, 30);
    wait_drained();

    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
